// File: rtl/tcce_pkg.sv
// ---------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcce_pkg;

   // field widths
   localparam int CHAR_W  = 8;
   localparam int CMD_W   = 2;
   localparam int POS_W   = 12;
   localparam int SPAN_W  = 13;
   localparam int ROW_W   = 13;
   localparam int CALC_W  = 14;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 13;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [SPAN_W-1:0] MAX_DIM = 13'd4096;
   localparam logic [SPAN_W-1:0] RESET_WIDTH  = 13'd1024;
   localparam logic [SPAN_W-1:0] RESET_HEIGHT = 13'd768;

   // control bytes
   localparam logic [CHAR_W-1:0] CHAR_BS     = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_LF     = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR     = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_ESC    = 8'd27;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_TWO    = 8'h32;
   localparam logic [CHAR_W-1:0] CHAR_THREE  = 8'h33;
   localparam logic [CHAR_W-1:0] CHAR_HOME   = 8'h48;
   localparam logic [CHAR_W-1:0] CHAR_CLEAR  = 8'h4A;
   localparam logic [CHAR_W-1:0] CHAR_LBRACK = 8'h5B;
   localparam logic [CHAR_W-1:0] CHAR_DEL    = 8'd127;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_GLYPH  = 2'd0,
      CMD_FILL   = 2'd1,
      CMD_SCROLL = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PH_TEXT  = 2'd0,
      PH_ESC   = 2'd1,
      PH_CSI   = 2'd2,
      PH_PARAM = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STEP_FIRST  = 2'd0,
      STEP_SCROLL = 2'd1,
      STEP_BOTTOM = 2'd2
   } step_type;

   // one classified byte: an optional leading command and an optional scroll
   typedef struct packed {
      logic                first_valid;
      cmd_type             first_cmd;
      logic [POS_W-1:0]    first_x;
      logic [POS_W-1:0]    first_y;
      logic [SPAN_W-1:0]   first_w;
      logic [SPAN_W-1:0]   first_h;
      logic [CHAR_W-1:0]   first_glyph;
      logic                scroll;
      logic [POS_W-1:0]    bottom;
      logic [SPAN_W-1:0]   width;
   } job_type;

endpackage

// File: rtl/tcce_front.sv
// ---------------------------------------------------------------------------
// tcce_front
// Escape parser and cursor tracker; turns each byte into at most one queue entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcce_front #(
   parameter int TOP_OFFSET = 20,
   parameter int GLYPH_W    = 8,
   parameter int GLYPH_H    = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcce_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                               req_valid,
   input  logic [tcce_pkg::CHAR_W-1:0]        req_char_code,
   input  logic                               queue_full,
   output logic                               req_stall,
   output logic                               push,
   output tcce_pkg::job_type                  push_job
);

   localparam logic [tcce_pkg::CALC_W-1:0] GW_C  = tcce_pkg::CALC_W'(GLYPH_W);
   localparam logic [tcce_pkg::CALC_W-1:0] GH_C  = tcce_pkg::CALC_W'(GLYPH_H);
   localparam logic [tcce_pkg::CALC_W-1:0] TOP_C = tcce_pkg::CALC_W'(TOP_OFFSET);

   logic [tcce_pkg::SPAN_W-1:0] width_ff, height_ff;
   logic [tcce_pkg::POS_W-1:0]  col_ff;
   logic [tcce_pkg::ROW_W-1:0]  row_ff;
   tcce_pkg::phase_type         phase_ff, phase_in;
   logic [tcce_pkg::CALC_W-1:0] col_in, row_in, row_text;
   logic [tcce_pkg::CALC_W-1:0] w_eff, h_eff, col_ext, row_ext, col_adv;
   logic [tcce_pkg::CALC_W-1:0] bottom, area;
   logic                        accept, scroll;
   tcce_pkg::job_type           job;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tcce_pkg::RESET_WIDTH;
         height_ff <= tcce_pkg::RESET_HEIGHT;
      end else if (csr_write) begin
         unique case (tcce_pkg::csr_index_type'(csr_index))
            tcce_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_data;
            tcce_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign w_eff = {1'b0, (width_ff > tcce_pkg::MAX_DIM) ? tcce_pkg::MAX_DIM : width_ff};
   assign h_eff = {1'b0, (height_ff > tcce_pkg::MAX_DIM) ? tcce_pkg::MAX_DIM : height_ff};
   assign col_ext = {2'b00, col_ff};
   assign row_ext = {1'b0, row_ff};
   assign col_adv = col_ext + GW_C;
   assign bottom  = (h_eff >= GH_C) ? (h_eff - GH_C) : '0;
   assign area    = (h_eff > TOP_C) ? (h_eff - TOP_C) : '0;

   // escape parser next state
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         tcce_pkg::PH_TEXT: begin
            if (req_char_code == tcce_pkg::CHAR_ESC) phase_in = tcce_pkg::PH_ESC;
         end
         tcce_pkg::PH_ESC: begin
            phase_in = (req_char_code == tcce_pkg::CHAR_LBRACK) ? tcce_pkg::PH_CSI
                                                                : tcce_pkg::PH_TEXT;
         end
         tcce_pkg::PH_CSI: begin
            if (req_char_code == tcce_pkg::CHAR_TWO || req_char_code == tcce_pkg::CHAR_THREE)
               phase_in = tcce_pkg::PH_PARAM;
            else
               phase_in = tcce_pkg::PH_TEXT;
         end
         tcce_pkg::PH_PARAM: phase_in = tcce_pkg::PH_TEXT;
         default: phase_in = tcce_pkg::PH_TEXT;
      endcase
   end

   // cursor update and command classification
   always_comb begin
      col_in   = col_ext;
      row_text = row_ext;
      job             = '0;
      job.first_cmd   = tcce_pkg::CMD_GLYPH;
      job.first_w     = tcce_pkg::SPAN_W'(GLYPH_W);
      job.first_h     = tcce_pkg::SPAN_W'(GLYPH_H);
      job.first_y     = row_ff[tcce_pkg::POS_W-1:0];
      job.width       = w_eff[tcce_pkg::SPAN_W-1:0];
      job.bottom      = bottom[tcce_pkg::POS_W-1:0];
      unique case (phase_ff)
         tcce_pkg::PH_TEXT: begin
            if (req_char_code == tcce_pkg::CHAR_ESC) begin
               col_in = col_ext;
            end else if (req_char_code == tcce_pkg::CHAR_LF) begin
               col_in   = '0;
               row_text = row_ext + GH_C;
            end else if (req_char_code == tcce_pkg::CHAR_CR) begin
               col_in = '0;
            end else if (req_char_code == tcce_pkg::CHAR_BS ||
                         req_char_code == tcce_pkg::CHAR_DEL) begin
               if (col_ext >= GW_C) begin
                  col_in          = col_ext - GW_C;
                  job.first_valid = 1'b1;
                  job.first_x     = col_in[tcce_pkg::POS_W-1:0];
                  job.first_glyph = tcce_pkg::CHAR_SPACE;
               end
            end else begin
               job.first_valid = 1'b1;
               job.first_x     = col_ff;
               job.first_glyph = req_char_code;
               if (col_adv + GW_C > w_eff) begin
                  col_in   = '0;
                  row_text = row_ext + GH_C;
               end else begin
                  col_in = col_adv;
               end
            end
         end
         tcce_pkg::PH_ESC: ;
         tcce_pkg::PH_CSI: begin
            if (req_char_code == tcce_pkg::CHAR_HOME) begin
               col_in   = '0;
               row_text = TOP_C;
            end
         end
         tcce_pkg::PH_PARAM: begin
            if (req_char_code == tcce_pkg::CHAR_CLEAR) begin
               job.first_valid = 1'b1;
               job.first_cmd   = tcce_pkg::CMD_FILL;
               job.first_y     = TOP_C[tcce_pkg::POS_W-1:0];
               job.first_w     = w_eff[tcce_pkg::SPAN_W-1:0];
               job.first_h     = area[tcce_pkg::SPAN_W-1:0];
            end
         end
         default: ;
      endcase
      // bottom check after every byte
      scroll     = (row_text + GH_C) > h_eff;
      job.scroll = scroll;
      row_in     = scroll ? bottom : row_text;
   end

   assign push     = accept && (job.first_valid || job.scroll);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= tcce_pkg::ROW_W'(TOP_OFFSET);
         phase_ff <= tcce_pkg::PH_TEXT;
      end else if (accept) begin
         col_ff   <= col_in[tcce_pkg::POS_W-1:0];
         row_ff   <= row_in[tcce_pkg::ROW_W-1:0];
         phase_ff <= phase_in;
      end
   end

endmodule

// File: rtl/tcce_queue.sv
// ---------------------------------------------------------------------------
// tcce_queue
// Short first-in first-out queue of classified requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcce_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcce_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output tcce_pkg::job_type head_job
);

   tcce_pkg::job_type               entry_ff [tcce_pkg::QUEUE_DEPTH];
   logic [tcce_pkg::QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [tcce_pkg::QUEUE_AW:0]     count_ff, count_in;

   assign full       = (count_ff == (tcce_pkg::QUEUE_AW+1)'(tcce_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/tcce_back.sv
// ---------------------------------------------------------------------------
// tcce_back
// Expands each queued request into its drawing commands, one per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcce_back #(
   parameter int TOP_OFFSET = 20,
   parameter int GLYPH_H    = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  tcce_pkg::job_type                head_job,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tcce_pkg::CMD_W-1:0]       rsp_cmd,
   output logic [tcce_pkg::POS_W-1:0]       rsp_pos_x,
   output logic [tcce_pkg::POS_W-1:0]       rsp_pos_y,
   output logic [tcce_pkg::SPAN_W-1:0]      rsp_span_w,
   output logic [tcce_pkg::SPAN_W-1:0]      rsp_span_h,
   output logic [tcce_pkg::CHAR_W-1:0]      rsp_glyph,
   output logic                             rsp_last
);

   tcce_pkg::step_type             step_ff, step_in, step_cur;
   logic                           load;
   logic                           rsp_valid_ff;
   logic [tcce_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [tcce_pkg::POS_W-1:0]     x_ff, x_in, y_ff, y_in;
   logic [tcce_pkg::SPAN_W-1:0]    w_ff, w_in, h_ff, h_in;
   logic [tcce_pkg::CHAR_W-1:0]    glyph_ff, glyph_in;
   logic                           last_ff, last_in;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign step_cur = (step_ff == tcce_pkg::STEP_FIRST && !head_job.first_valid)
                   ? tcce_pkg::STEP_SCROLL : step_ff;

   // sequencer next state
   always_comb begin
      step_in = step_ff;
      if (load) begin
         unique case (step_cur)
            tcce_pkg::STEP_FIRST:
               step_in = head_job.scroll ? tcce_pkg::STEP_SCROLL : tcce_pkg::STEP_FIRST;
            tcce_pkg::STEP_SCROLL: step_in = tcce_pkg::STEP_BOTTOM;
            tcce_pkg::STEP_BOTTOM: step_in = tcce_pkg::STEP_FIRST;
            default:               step_in = tcce_pkg::STEP_FIRST;
         endcase
      end
   end

   // command for the current step
   always_comb begin
      cmd_in   = tcce_pkg::CMD_FILL;
      x_in     = '0;
      y_in     = tcce_pkg::POS_W'(TOP_OFFSET);
      w_in     = head_job.width;
      h_in     = tcce_pkg::SPAN_W'(GLYPH_H);
      glyph_in = '0;
      last_in  = 1'b0;
      unique case (step_cur)
         tcce_pkg::STEP_FIRST: begin
            cmd_in   = head_job.first_cmd;
            x_in     = head_job.first_x;
            y_in     = head_job.first_y;
            w_in     = head_job.first_w;
            h_in     = head_job.first_h;
            glyph_in = head_job.first_glyph;
            last_in  = !head_job.scroll;
         end
         tcce_pkg::STEP_SCROLL: cmd_in = tcce_pkg::CMD_SCROLL;
         tcce_pkg::STEP_BOTTOM: begin
            y_in    = head_job.bottom;
            last_in = 1'b1;
         end
         default: ;
      endcase
   end

   assign pop = load && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= tcce_pkg::STEP_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= load || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff   <= cmd_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         glyph_ff <= glyph_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cmd    = cmd_ff;
   assign rsp_pos_x  = x_ff;
   assign rsp_pos_y  = y_ff;
   assign rsp_span_w = w_ff;
   assign rsp_span_h = h_ff;
   assign rsp_glyph  = glyph_ff;
   assign rsp_last   = last_ff;

endmodule

// File: rtl/text_console_cursor_engine.sv
// ---------------------------------------------------------------------------
// text_console_cursor_engine
// Console byte stream in, glyph / fill / scroll drawing commands out.
// ---------------------------------------------------------------------------
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     char_code
//   rsp      out        rsp_valid/stall     cmd pos_x pos_y span_w span_h glyph last
//   csr      in         csr_write           csr_index csr_data
//
// the front takes one byte per cycle while the request queue has room
// the back gives one command per cycle while the output is not stalled, so a byte yields 0 to 3 commands there
// (none without output; glyph or clear, then scroll and bottom-row clear)
// sync reset homes the cursor, clears the parser and loads 1024x768
// a stalled result holds in the output register while the queue keeps filling
`timescale 1ns / 1ps

module text_console_cursor_engine #(
   parameter int TOP_OFFSET = 20,
   parameter int GLYPH_W    = 8,
   parameter int GLYPH_H    = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcce_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tcce_pkg::CHAR_W-1:0]      req_char_code,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tcce_pkg::CMD_W-1:0]       rsp_cmd,
   output logic [tcce_pkg::POS_W-1:0]       rsp_pos_x,
   output logic [tcce_pkg::POS_W-1:0]       rsp_pos_y,
   output logic [tcce_pkg::SPAN_W-1:0]      rsp_span_w,
   output logic [tcce_pkg::SPAN_W-1:0]      rsp_span_h,
   output logic [tcce_pkg::CHAR_W-1:0]      rsp_glyph,
   output logic                             rsp_last
);

   logic              push, pop, queue_full, head_valid;
   tcce_pkg::job_type push_job, head_job;

   tcce_front #(
      .TOP_OFFSET (TOP_OFFSET),
      .GLYPH_W    (GLYPH_W),
      .GLYPH_H    (GLYPH_H)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_char_code (req_char_code),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push          (push),
      .push_job      (push_job)
   );

   tcce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   tcce_back #(
      .TOP_OFFSET (TOP_OFFSET),
      .GLYPH_H    (GLYPH_H)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_cmd    (rsp_cmd),
      .rsp_pos_x  (rsp_pos_x),
      .rsp_pos_y  (rsp_pos_y),
      .rsp_span_w (rsp_span_w),
      .rsp_span_h (rsp_span_h),
      .rsp_glyph  (rsp_glyph),
      .rsp_last   (rsp_last)
   );

endmodule
